>>> rtl/core/pcj_pkg.sv
// Package for the penalty contact Jacobian core.
// Holds the transfer structs, fixed-point constants and helper functions. No dependencies.
`timescale 1ns / 1ps
package pcj_pkg;

  localparam int unsigned ValueWidthDef   = 32;
  localparam int unsigned FractionBitsDef = 16;
  localparam logic [31:0] StiffnessReset  = 32'd327680;
  localparam logic signed [63:0] InnerLim = 64'sh3FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    QtyForce  = 3'd0,
    QtyTorque = 3'd1,
    QtyDfDx   = 3'd2,
    QtyDfDw   = 3'd3,
    QtyDtDx   = 3'd4,
    QtyDtDw   = 3'd5
  } qty_e;

  typedef struct packed {
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] depth;
    logic signed [31:0] arm_x;
    logic signed [31:0] arm_y;
    logic signed [31:0] arm_z;
  } contact_t;

  typedef struct packed {
    logic [2:0]         quantity;
    logic [1:0]         row;
    logic signed [31:0] col0;
    logic signed [31:0] col1;
    logic signed [31:0] col2;
    logic               saturated;
    logic               last;
  } result_t;

  // Value with sticky clip mark.
  typedef struct packed {
    logic signed [63:0] v;
    logic               s;
  } fx_t;

  typedef fx_t [2:0] vec_t;
  typedef vec_t [2:0] mat_t;

  function automatic fx_t fx_make(input logic signed [64:0] v, input logic s);
    fx_t r;
    r.s = s;
    if (v > 65'(InnerLim)) begin
      r.v = InnerLim;
      r.s = 1'b1;
    end else if (v < -65'(InnerLim)) begin
      r.v = -InnerLim;
      r.s = 1'b1;
    end else begin
      r.v = v[63:0];
    end
    return r;
  endfunction

  function automatic fx_t fx_add(input fx_t a, input fx_t b);
    return fx_make(65'(a.v) + 65'(b.v), a.s | b.s);
  endfunction

  function automatic fx_t fx_neg(input fx_t a);
    return fx_make(-65'(a.v), a.s);
  endfunction

  function automatic fx_t fx_sub(input fx_t a, input fx_t b);
    return fx_add(a, fx_neg(b));
  endfunction

  function automatic mat_t skew(input vec_t v);
    mat_t m;
    fx_t  z;
    z = '0;
    m[0][0] = z;         m[0][1] = fx_neg(v[2]); m[0][2] = v[1];
    m[1][0] = v[2];      m[1][1] = z;            m[1][2] = fx_neg(v[0]);
    m[2][0] = fx_neg(v[1]); m[2][1] = v[0];      m[2][2] = z;
    return m;
  endfunction

endpackage

>>> rtl/core/pcj_mul.sv
// Pipelined fixed-point multiplier: rounds to nearest, ties away, clips to the internal range.
// Two register stages: 32x32 partial products, then sum, rounding and clip. Depends on pcj_pkg.
`timescale 1ns / 1ps
module pcj_mul #(
  parameter int unsigned FractionBits = pcj_pkg::FractionBitsDef
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  pcj_pkg::fx_t  a_i,
  input  pcj_pkg::fx_t  b_i,
  output pcj_pkg::fx_t  p_o
);

  logic [63:0]  ua, ub;
  logic         neg_q, s_q;
  logic [63:0]  p00_q, p01_q, p10_q, p11_q;
  logic [127:0] prod;
  logic [127:0] rnd;
  logic [63:0]  q;
  logic         sq;

  function automatic logic [63:0] InnerLimU();
    return 64'(pcj_pkg::InnerLim);
  endfunction

  assign ua = a_i.v[63] ? 64'(-a_i.v) : 64'(a_i.v);
  assign ub = b_i.v[63] ? 64'(-b_i.v) : 64'(b_i.v);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q <= 64'(ua[31:0]) * 64'(ub[31:0]);
      p01_q <= 64'(ua[31:0]) * 64'(ub[63:32]);
      p10_q <= 64'(ua[63:32]) * 64'(ub[31:0]);
      p11_q <= 64'(ua[63:32]) * 64'(ub[63:32]);
      neg_q <= a_i.v[63] ^ b_i.v[63];
      s_q   <= a_i.s | b_i.s;
    end
  end

  always_comb begin
    prod = (128'(p11_q) << 64) + (128'(p01_q) << 32) + (128'(p10_q) << 32) + 128'(p00_q);
    rnd  = prod + (128'd1 << (FractionBits - 1));
    sq   = s_q;
    if ((rnd >> FractionBits) > 128'(InnerLimU())) begin
      q  = 64'(InnerLimU());
      sq = 1'b1;
    end else begin
      q = 64'(rnd >> FractionBits);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o <= pcj_pkg::fx_make(neg_q ? -65'(q) : 65'(q), sq);
    end
  end

endmodule

>>> rtl/core/penalty_contact_jacobian_core.sv
// Penalty contact force, torque and Jacobian core, top level.
// Depends on pcj_pkg and pcj_mul.
`timescale 1ns / 1ps
// One contact in, fourteen rows out (force, torque, then three rows each of
// dF/dX, dF/dOmega, dT/dX, dT/dOmega). Contacts flow through a nine-stage
// pipeline of multiplier and adder stages and collect in a two-entry queue of
// result sets; admission is credited against that queue, so the pipeline never
// stalls. The output port drains one row per cycle unless out_stall_i is high,
// and the sustained rate is set by the single result port. On an empty core
// the first row is valid once its result set is in the queue. Stiffness is
// written via the cfg port by the user only while idle; the core does not enforce it.
module penalty_contact_jacobian_core #(
  parameter int unsigned VALUE_WIDTH   = pcj_pkg::ValueWidthDef,
  parameter int unsigned FRACTION_BITS = pcj_pkg::FractionBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pcj_pkg::contact_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pcj_pkg::result_t    out_data_o
);

  localparam int unsigned Depth = 9;
  localparam int unsigned QDepth = 2;

  logic [31:0] k_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= pcj_pkg::StiffnessReset;
    end else if (cfg_valid_i) begin
      k_q <= cfg_data_i;
    end
  end

  // Credit-based admission: a contact enters only when a queue slot is free
  // counting those in flight.
  logic [Depth-1:0] vld_q;
  logic [1:0]       cnt_q;
  logic [3:0]       rd_q;
  logic             wp_q, rp_q;
  logic             accept, pop_set, push;
  logic [3:0]       occ;

  assign occ        = 4'(cnt_q) + 4'($countones(vld_q));
  assign in_stall_o = (occ >= 4'(QDepth));
  assign accept     = in_valid_i & ~in_stall_o;
  assign push       = vld_q[Depth-1];

  // ---- stage 0: capture ----
  pcj_pkg::vec_t n0, r0;
  pcj_pkg::fx_t  d0, dn0, k0;
  always_comb begin
    n0[0] = '{v: 64'(in_data_i.normal_x), s: 1'b0};
    n0[1] = '{v: 64'(in_data_i.normal_y), s: 1'b0};
    n0[2] = '{v: 64'(in_data_i.normal_z), s: 1'b0};
    r0[0] = '{v: 64'(in_data_i.arm_x), s: 1'b0};
    r0[1] = '{v: 64'(in_data_i.arm_y), s: 1'b0};
    r0[2] = '{v: 64'(in_data_i.arm_z), s: 1'b0};
    d0    = '{v: 64'(in_data_i.depth), s: 1'b0};
    dn0   = (in_data_i.depth > 0) ? '0 : d0;
    k0    = '{v: {32'd0, k_q}, s: 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Depth-2:0], accept};
    end
  end

  // Delay lines for operands reused by later levels.
  pcj_pkg::vec_t n_d [Depth];
  pcj_pkg::vec_t r_d [Depth];
  pcj_pkg::fx_t  k_d [Depth];
  always_ff @(posedge clk_i) begin
    n_d[0] <= n0;
    r_d[0] <= r0;
    k_d[0] <= k0;
    for (int i = 1; i < Depth; i++) begin
      n_d[i] <= n_d[i-1];
      r_d[i] <= r_d[i-1];
      k_d[i] <= k_d[i-1];
    end
  end

  // ---- level A: kd, kdn, n_i n_j ----
  pcj_pkg::fx_t kd_a, kdn_a;
  pcj_pkg::fx_t nn_a [3][3];
  pcj_mul #(.FractionBits(FRACTION_BITS)) u_kd (
    .clk_i, .en_i(1'b1), .a_i(k0), .b_i(d0), .p_o(kd_a));
  pcj_mul #(.FractionBits(FRACTION_BITS)) u_kdn (
    .clk_i, .en_i(1'b1), .a_i(k0), .b_i(dn0), .p_o(kdn_a));
  for (genvar i = 0; i < 3; i++) begin : g_nn
    for (genvar j = 0; j < 3; j++) begin : g_nnj
      pcj_mul #(.FractionBits(FRACTION_BITS)) u_m (
        .clk_i, .en_i(1'b1), .a_i(n0[i]), .b_i(n0[j]), .p_o(nn_a[i][j]));
    end
  end

  // ---- level B: kM, F ----
  pcj_pkg::mat_t km_b;
  pcj_pkg::vec_t f_b;
  for (genvar i = 0; i < 3; i++) begin : g_km
    for (genvar j = 0; j < 3; j++) begin : g_kmj
      pcj_mul #(.FractionBits(FRACTION_BITS)) u_m (
        .clk_i, .en_i(1'b1), .a_i(k_d[1]), .b_i(nn_a[i][j]), .p_o(km_b[i][j]));
    end
    pcj_mul #(.FractionBits(FRACTION_BITS)) u_f (
      .clk_i, .en_i(1'b1), .a_i(kdn_a), .b_i(n_d[1][i]), .p_o(f_b[i]));
  end
  pcj_pkg::fx_t kd_b [2];
  always_ff @(posedge clk_i) begin
    kd_b[0] <= kd_a;
    kd_b[1] <= kd_b[0];
  end

  // ---- level C: T terms, kM R, R kM, kd*SN, F x R, kd*(R SN) prep ----
  pcj_pkg::mat_t rm_c, sn_c, sf_c;
  always_comb begin
    rm_c = pcj_pkg::skew(r_d[3]);
    sn_c = pcj_pkg::skew(n_d[3]);
    sf_c = pcj_pkg::skew(f_b);
  end
  pcj_pkg::fx_t tp_c [3][2];
  pcj_pkg::fx_t kmr_c [3][3][3];
  pcj_pkg::fx_t rkm_c [3][3][3];
  pcj_pkg::fx_t sfr_c [3][3][3];
  pcj_pkg::fx_t rsn_c [3][3][3];
  pcj_pkg::fx_t kdsn_c [3][3];
  for (genvar i = 0; i < 3; i++) begin : g_c
    pcj_mul #(.FractionBits(FRACTION_BITS)) u_t0 (.clk_i, .en_i(1'b1),
      .a_i(r_d[3][(i+1)%3]), .b_i(f_b[(i+2)%3]), .p_o(tp_c[i][0]));
    pcj_mul #(.FractionBits(FRACTION_BITS)) u_t1 (.clk_i, .en_i(1'b1),
      .a_i(r_d[3][(i+2)%3]), .b_i(f_b[(i+1)%3]), .p_o(tp_c[i][1]));
    for (genvar j = 0; j < 3; j++) begin : g_cj
      pcj_mul #(.FractionBits(FRACTION_BITS)) u_kdsn (.clk_i, .en_i(1'b1),
        .a_i(kd_b[1]), .b_i(sn_c[i][j]), .p_o(kdsn_c[i][j]));
      for (genvar m = 0; m < 3; m++) begin : g_cm
        pcj_mul #(.FractionBits(FRACTION_BITS)) u_a (.clk_i, .en_i(1'b1),
          .a_i(km_b[i][m]), .b_i(rm_c[m][j]), .p_o(kmr_c[i][j][m]));
        pcj_mul #(.FractionBits(FRACTION_BITS)) u_b (.clk_i, .en_i(1'b1),
          .a_i(rm_c[i][m]), .b_i(km_b[m][j]), .p_o(rkm_c[i][j][m]));
        pcj_mul #(.FractionBits(FRACTION_BITS)) u_c (.clk_i, .en_i(1'b1),
          .a_i(sf_c[i][m]), .b_i(rm_c[m][j]), .p_o(sfr_c[i][j][m]));
        pcj_mul #(.FractionBits(FRACTION_BITS)) u_d (.clk_i, .en_i(1'b1),
          .a_i(rm_c[i][m]), .b_i(sn_c[m][j]), .p_o(rsn_c[i][j][m]));
      end
    end
  end
  pcj_pkg::vec_t f_c [2];
  pcj_pkg::mat_t km_c [2];
  pcj_pkg::fx_t  kd_c [2];
  always_ff @(posedge clk_i) begin
    f_c[0]  <= f_b;     f_c[1]  <= f_c[0];
    km_c[0] <= km_b;    km_c[1] <= km_c[0];
    kd_c[0] <= kd_b[1]; kd_c[1] <= kd_c[0];
  end

  // ---- level D: sums of products ----
  pcj_pkg::vec_t f_e, t_e;
  pcj_pkg::mat_t km_e, a_e, rkm_e, sfr_e, rsn_e, kdsn_e, sf_e;
  pcj_pkg::fx_t  kd_e;
  always_ff @(posedge clk_i) begin
    f_e  <= f_c[1];
    km_e <= km_c[1];
    kd_e <= kd_c[1];
    sf_e <= pcj_pkg::skew(f_c[1]);
    for (int i = 0; i < 3; i++) begin
      t_e[i] <= pcj_pkg::fx_sub(tp_c[i][0], tp_c[i][1]);
      for (int j = 0; j < 3; j++) begin
        a_e[i][j]    <= pcj_pkg::fx_add(pcj_pkg::fx_add(kmr_c[i][j][0], kmr_c[i][j][1]),
                                        kmr_c[i][j][2]);
        rkm_e[i][j]  <= pcj_pkg::fx_add(pcj_pkg::fx_add(rkm_c[i][j][0], rkm_c[i][j][1]),
                                        rkm_c[i][j][2]);
        sfr_e[i][j]  <= pcj_pkg::fx_add(pcj_pkg::fx_add(sfr_c[i][j][0], sfr_c[i][j][1]),
                                        sfr_c[i][j][2]);
        rsn_e[i][j]  <= pcj_pkg::fx_add(pcj_pkg::fx_add(rsn_c[i][j][0], rsn_c[i][j][1]),
                                        rsn_c[i][j][2]);
        kdsn_e[i][j] <= kdsn_c[i][j];
      end
    end
  end

  // ---- level E: RkM R and kd*(R SN) ----
  pcj_pkg::fx_t bp_f [3][3][3];
  pcj_pkg::fx_t kc_f [3][3];
  pcj_pkg::mat_t rm_e;
  always_comb rm_e = pcj_pkg::skew(r_d[Depth-3]);
  for (genvar i = 0; i < 3; i++) begin : g_e
    for (genvar j = 0; j < 3; j++) begin : g_ej
      pcj_mul #(.FractionBits(FRACTION_BITS)) u_kc (.clk_i, .en_i(1'b1),
        .a_i(kd_e), .b_i(rsn_e[i][j]), .p_o(kc_f[i][j]));
      for (genvar m = 0; m < 3; m++) begin : g_em
        pcj_mul #(.FractionBits(FRACTION_BITS)) u_b (.clk_i, .en_i(1'b1),
          .a_i(rkm_e[i][m]), .b_i(rm_e[m][j]), .p_o(bp_f[i][j][m]));
      end
    end
  end
  pcj_pkg::vec_t f_g [2], t_g [2];
  pcj_pkg::mat_t km_g [2], a_g [2], rkm_g [2], sfr_g [2], kdsn_g [2], sf_g [2];
  always_ff @(posedge clk_i) begin
    f_g[0] <= f_e; t_g[0] <= t_e; km_g[0] <= km_e; a_g[0] <= a_e;
    rkm_g[0] <= rkm_e; sfr_g[0] <= sfr_e; kdsn_g[0] <= kdsn_e; sf_g[0] <= sf_e;
    f_g[1] <= f_g[0]; t_g[1] <= t_g[0]; km_g[1] <= km_g[0]; a_g[1] <= a_g[0];
    rkm_g[1] <= rkm_g[0]; sfr_g[1] <= sfr_g[0]; kdsn_g[1] <= kdsn_g[0];
    sf_g[1] <= sf_g[0];
  end

  // ---- final: rows, output clip, into the set queue ----
  localparam logic signed [63:0] OutHi = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] OutLo = -OutHi - 64'sd1;

  function automatic logic [96:0] pack_row(input pcj_pkg::vec_t e);
    logic [96:0] r;
    logic        s;
    logic signed [63:0] v;
    s = 1'b0;
    r = '0;
    for (int j = 0; j < 3; j++) begin
      v = e[j].v;
      s = s | e[j].s;
      if (v > OutHi) begin
        v = OutHi;
        s = 1'b1;
      end
      if (v < OutLo) begin
        v = OutLo;
        s = 1'b1;
      end
      r[96-32*j -: 32] = v[31:0];
    end
    r[0] = s;
    return r;
  endfunction

  logic [96:0] rows [14];
  always_comb begin
    pcj_pkg::vec_t e;
    pcj_pkg::fx_t  acc;
    rows[0] = pack_row(f_g[1]);
    rows[1] = pack_row(t_g[1]);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) e[j] = pcj_pkg::fx_neg(km_g[1][i][j]);
      rows[2+i] = pack_row(e);
      for (int j = 0; j < 3; j++) e[j] = pcj_pkg::fx_add(a_g[1][i][j], kdsn_g[1][i][j]);
      rows[5+i] = pack_row(e);
      for (int j = 0; j < 3; j++) e[j] = pcj_pkg::fx_sub(sf_g[1][i][j], rkm_g[1][i][j]);
      rows[8+i] = pack_row(e);
      for (int j = 0; j < 3; j++) begin
        acc = pcj_pkg::fx_add(pcj_pkg::fx_add(bp_f[i][j][0], bp_f[i][j][1]), bp_f[i][j][2]);
        acc = pcj_pkg::fx_add(pcj_pkg::fx_neg(sfr_g[1][i][j]), acc);
        e[j] = pcj_pkg::fx_add(acc, kc_f[i][j]);
      end
      rows[11+i] = pack_row(e);
    end
  end

  logic [96:0] set_mem [QDepth][14];
  always_ff @(posedge clk_i) begin
    if (push) begin
      for (int i = 0; i < 14; i++) set_mem[wp_q][i] <= rows[i];
    end
  end

  assign pop_set = out_valid_o & ~out_stall_i & (rd_q == 4'd13);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= '0;
      rp_q  <= '0;
      rd_q  <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop_set) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + 2'(push) - 2'(pop_set);
      if (out_valid_o && !out_stall_i) rd_q <= (rd_q == 4'd13) ? 4'd0 : rd_q + 4'd1;
    end
  end

  logic [96:0] cur;
  logic [2:0]  qty;
  logic [1:0]  rw;
  assign cur = set_mem[rp_q][rd_q];
  always_comb begin
    unique case (rd_q) inside
      4'd1:          qty = pcj_pkg::QtyTorque;
      [4'd2:4'd4]:   qty = pcj_pkg::QtyDfDx;
      [4'd5:4'd7]:   qty = pcj_pkg::QtyDfDw;
      [4'd8:4'd10]:  qty = pcj_pkg::QtyDtDx;
      [4'd11:4'd13]: qty = pcj_pkg::QtyDtDw;
      default:       qty = pcj_pkg::QtyForce;
    endcase
    unique case (rd_q) inside
      4'd3, 4'd6, 4'd9, 4'd12:  rw = 2'd1;
      4'd4, 4'd7, 4'd10, 4'd13: rw = 2'd2;
      default:                  rw = 2'd0;
    endcase
  end
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = '{quantity: qty, row: rw, col0: cur[96:65], col1: cur[64:33],
                         col2: cur[32:1], saturated: cur[0], last: (rd_q == 4'd13)};

`ifndef SYNTH
  a_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= 4'(QDepth)) else $error("set queue overrun");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.quantity == pcj_pkg::QtyDtDw)
    else $error("last on wrong row");
  a_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_q <= 4'd13) else $error("row counter out of range");
`endif

endmodule

>>> verif/tb_penalty_contact_jacobian_core.sv
// Testbench for penalty_contact_jacobian_core: drives contacts, predicts the 14 result rows.
// Depends on pcj_pkg and the core RTL; self-checking, no external files.
`timescale 1ns / 1ps
module tb_penalty_contact_jacobian_core;

  localparam int ClkPeriod = 10;
  localparam int RandomContacts = 430;
  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles = 40;
  localparam logic signed [63:0] Lim = 64'sh3FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic signed [63:0] v;
    bit s;
  } num_t;
  typedef num_t nvec_t [3];
  typedef num_t nmat_t [3][3];

  typedef struct {
    pcj_pkg::contact_t c;
    bit has_fixed;
    pcj_pkg::result_t fixed_first;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  pcj_pkg::contact_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  pcj_pkg::result_t out_data_o;

  penalty_contact_jacobian_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  pcj_pkg::result_t expected_rows[$];
  logic [31:0] stiffness = pcj_pkg::StiffnessReset;
  int mismatches = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  function automatic num_t mk(logic signed [65:0] v, bit s);
    num_t r;
    r.s = s;
    if (v > 66'(Lim)) begin
      r.v = Lim;
      r.s = 1'b1;
    end else if (v < -66'(Lim)) begin
      r.v = -Lim;
      r.s = 1'b1;
    end else begin
      r.v = v[63:0];
    end
    return r;
  endfunction

  function automatic num_t add_n(num_t a, num_t b);
    return mk(66'(a.v) + 66'(b.v), a.s | b.s);
  endfunction

  function automatic num_t neg_n(num_t a);
    return mk(-66'(a.v), a.s);
  endfunction

  function automatic num_t sub_n(num_t a, num_t b);
    return add_n(a, neg_n(b));
  endfunction

  function automatic num_t mul_n(num_t a, num_t b);
    logic [63:0] ua, ub;
    logic [127:0] p, q;
    bit neg, s;
    neg = (a.v < 0) != (b.v < 0);
    ua = a.v < 0 ? -a.v : a.v;
    ub = b.v < 0 ? -b.v : b.v;
    p = 128'(ua) * 128'(ub) + (128'd1 << (pcj_pkg::FractionBitsDef - 1));
    q = p >> pcj_pkg::FractionBitsDef;
    s = a.s | b.s;
    if (q > 128'(Lim)) begin
      q = 128'(Lim);
      s = 1'b1;
    end
    return mk(neg ? -66'(q[63:0]) : 66'(q[63:0]), s);
  endfunction

  function automatic nmat_t skew_n(nvec_t v);
    nmat_t m;
    num_t z;
    z.v = 0;
    z.s = 0;
    m[0][0] = z;            m[0][1] = neg_n(v[2]); m[0][2] = v[1];
    m[1][0] = v[2];         m[1][1] = z;           m[1][2] = neg_n(v[0]);
    m[2][0] = neg_n(v[1]);  m[2][1] = v[0];        m[2][2] = z;
    return m;
  endfunction

  function automatic nmat_t matmul_n(nmat_t a, nmat_t b);
    nmat_t c;
    num_t acc;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = mul_n(a[i][0], b[0][j]);
        acc = add_n(acc, mul_n(a[i][1], b[1][j]));
        c[i][j] = add_n(acc, mul_n(a[i][2], b[2][j]));
      end
    end
    return c;
  endfunction

  function automatic pcj_pkg::result_t pack_row(int idx, pcj_pkg::qty_e qty, int r, nvec_t e);
    pcj_pkg::result_t o;
    logic signed [63:0] v;
    logic [31:0] cols [3];
    bit sat;
    sat = 1'b0;
    for (int j = 0; j < 3; j++) begin
      v = e[j].v;
      sat |= e[j].s;
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647;
        sat = 1'b1;
      end
      if (v < -64'sd2147483648) begin
        v = -64'sd2147483648;
        sat = 1'b1;
      end
      cols[j] = v[31:0];
    end
    o.quantity = qty;
    o.row = r[1:0];
    o.col0 = cols[0];
    o.col1 = cols[1];
    o.col2 = cols[2];
    o.saturated = sat;
    o.last = (idx == 13);
    return o;
  endfunction

  task automatic predict_contact(pcj_pkg::contact_t c);
    nvec_t n, a, f, t, row;
    nmat_t km, rs, sn, sf, m1, m2, m3, rkm;
    num_t k, d, dn, kd, kdn;
    int idx;
    idx = 0;
    n[0] = mk(66'(c.normal_x), 0);
    n[1] = mk(66'(c.normal_y), 0);
    n[2] = mk(66'(c.normal_z), 0);
    a[0] = mk(66'(c.arm_x), 0);
    a[1] = mk(66'(c.arm_y), 0);
    a[2] = mk(66'(c.arm_z), 0);
    d = mk(66'(c.depth), 0);
    k = mk(66'({1'b0, stiffness}), 0);
    dn = d.v > 0 ? mk(0, 0) : d;
    kd = mul_n(k, d);
    kdn = mul_n(k, dn);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) km[i][j] = mul_n(k, mul_n(n[i], n[j]));
      f[i] = mul_n(kdn, n[i]);
    end
    t[0] = sub_n(mul_n(a[1], f[2]), mul_n(a[2], f[1]));
    t[1] = sub_n(mul_n(a[2], f[0]), mul_n(a[0], f[2]));
    t[2] = sub_n(mul_n(a[0], f[1]), mul_n(a[1], f[0]));
    rs = skew_n(a);
    sn = skew_n(n);
    sf = skew_n(f);
    expected_rows.push_back(pack_row(idx++, pcj_pkg::QtyForce, 0, f));
    expected_rows.push_back(pack_row(idx++, pcj_pkg::QtyTorque, 0, t));
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) row[j] = neg_n(km[i][j]);
      expected_rows.push_back(pack_row(idx++, pcj_pkg::QtyDfDx, i, row));
    end
    m1 = matmul_n(km, rs);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) row[j] = add_n(m1[i][j], mul_n(kd, sn[i][j]));
      expected_rows.push_back(pack_row(idx++, pcj_pkg::QtyDfDw, i, row));
    end
    rkm = matmul_n(rs, km);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) row[j] = sub_n(sf[i][j], rkm[i][j]);
      expected_rows.push_back(pack_row(idx++, pcj_pkg::QtyDtDx, i, row));
    end
    m1 = matmul_n(sf, rs);
    m2 = matmul_n(rkm, rs);
    m3 = matmul_n(rs, sn);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        row[j] = add_n(add_n(neg_n(m1[i][j]), m2[i][j]), mul_n(kd, m3[i][j]));
      end
      expected_rows.push_back(pack_row(idx++, pcj_pkg::QtyDtDw, i, row));
    end
  endtask

  task automatic send_contact(pcj_pkg::contact_t c);
    in_data_i <= c;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_contact(c);
    @(negedge clk_i);
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (expected_rows.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_stiffness(logic [31:0] k);
    cfg_data_i <= k;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    stiffness = k;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000 | $urandom_range(0, 3);
      2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return 32'($signed($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  function automatic pcj_pkg::contact_t rand_contact();
    pcj_pkg::contact_t c;
    c.normal_x = rand_val();
    c.normal_y = rand_val();
    c.normal_z = rand_val();
    c.depth = rand_val();
    c.arm_x = rand_val();
    c.arm_y = rand_val();
    c.arm_z = rand_val();
    return c;
  endfunction

  function automatic pcj_pkg::contact_t mkc(int nx, int ny, int nz, int dp, int ax, int ay,
                                            int az);
    pcj_pkg::contact_t c;
    c.normal_x = nx;
    c.normal_y = ny;
    c.normal_z = nz;
    c.depth = dp;
    c.arm_x = ax;
    c.arm_y = ay;
    c.arm_z = az;
    return c;
  endfunction

  // Directed contacts; the zero contact's force row is known up front.
  stim_row_t directed[$];

  initial begin
    stim_row_t sr;
    pcj_pkg::result_t zero_force;
    int burst;
    zero_force = '0;
    zero_force.quantity = pcj_pkg::QtyForce;
    sr.has_fixed = 0;
    sr.fixed_first = '0;
    sr.c = '0;
    sr.has_fixed = 1;
    sr.fixed_first = zero_force;
    directed.push_back(sr);
    sr.has_fixed = 0;
    sr.c = mkc(0, 0, 65536, -6554, 0, 0, 0);      directed.push_back(sr);
    sr.c = mkc(65536, 0, 0, 32768, 0, 65536, 0);  directed.push_back(sr);
    sr.c = mkc(0, 65536, 0, -65536, 65536, 0, 65536); directed.push_back(sr);
    sr.c = mkc(46341, 46341, 0, -3277, 13107, -6554, 19661); directed.push_back(sr);
    sr.c = mkc(131072, -65536, 32768, -65536, 65536, 65536, 65536); directed.push_back(sr);
    sr.c = mkc(-1, -1, -1, -1, -1, -1, -1);       directed.push_back(sr);
    sr.c = mkc(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
               32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF); directed.push_back(sr);
    sr.c = mkc(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
               32'h80000000, 32'h80000000, 32'h80000000); directed.push_back(sr);
    sr.c = mkc(32'h80000000, 32'h7FFFFFFF, 0, 32'h80000000,
               32'h7FFFFFFF, 32'h80000000, 1); directed.push_back(sr);
    sr.c = mkc(1, 1, 1, 0, 1, 1, 1);               directed.push_back(sr);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].has_fixed) begin
        send_contact(directed[i].c);
        expected_rows[expected_rows.size() - 14] = directed[i].fixed_first;
      end else begin
        send_contact(directed[i].c);
      end
    end
    drop_valid();
    wait_idle();

    // Stiffness extremes on a few contacts each.
    foreach (directed[i]) begin
      if (i == 0) write_stiffness(32'hFFFF_FFFF);
      if (i == 4) write_stiffness(32'd0);
      if (i == 8) write_stiffness(32'd1);
      if (i == 0 || i == 4 || i == 8) begin
        send_contact(directed[i + 4 < directed.size() ? i + 4 : i].c);
        send_contact(directed[i + 1].c);
        drop_valid();
        wait_idle();
      end
    end
    write_stiffness(32'h0001_8000);

    // Backpressure: receiver holds off while contacts keep coming.
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++) send_contact(rand_contact());
    drop_valid();
    wait_idle();

    for (int i = 0; i < RandomContacts; i++) begin
      if (i % 100 == 99) begin
        drop_valid();
        wait_idle();
        write_stiffness(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1 << 20));
      end
      send_contact(rand_contact());
      if (burst <= 0) begin
        burst = $urandom_range(1, 8);
        drop_valid();
        repeat ($urandom_range(1, 30)) @(negedge clk_i);
      end
      burst--;
    end
    drop_valid();
    wait_idle();
    stim_done = 1'b1;
  end

  // Output stall pattern and the long hold-off.
  initial begin
    int cnt;
    cnt = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off && cnt < 400) begin
        out_stall_i <= 1'b1;
        cnt++;
      end else if (($urandom_range(0, 199) / 50) % 2 == 1) begin
        out_stall_i <= ($urandom_range(0, 2) == 0);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    pcj_pkg::result_t exp_row;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer %p", out_data_o);
      end else begin
        exp_row = expected_rows.pop_front();
        if (out_data_o !== exp_row) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_row, out_data_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(posedge rst_ni);
    while (!stim_done && idle_cycles < WatchdogLimit) @(posedge clk_i);
    if (!stim_done) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      if (mismatches == 0 && expected_rows.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
    end
  end

endmodule

>>> penalty_contact_jacobian_core.f
rtl/core/pcj_pkg.sv
rtl/core/pcj_mul.sv
rtl/core/penalty_contact_jacobian_core.sv
verif/tb_penalty_contact_jacobian_core.sv
